>>> hw/rtl/ffha_pkg.sv
// Shared types, codes and default sizes for the first-fit heap allocator.
// No dependencies; imported by first_fit_heap_allocator and its testbench.
package ffha_pkg;

	localparam int unsigned HEAP_BYTES_DEF   = 65536;
	localparam int unsigned ALIGN_BYTES_DEF  = 8;
	localparam int unsigned HEADER_BYTES_DEF = 16;

	localparam int unsigned HEAP_SIZE_W  = 17;
	localparam int unsigned REQ_SIZE_W   = 16;
	localparam int unsigned REQ_ADDR_W   = 16;
	localparam int unsigned RES_ADDR_W   = 16;
	localparam int unsigned FREE_BYTES_W = 17;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ZERO    = 2'd1;
	localparam logic [1:0] ST_NOFIT   = 2'd2;
	localparam logic [1:0] ST_BADFREE = 2'd3;

	typedef struct packed {
		logic                  req_type;
		logic [REQ_SIZE_W-1:0] req_size;
		logic [REQ_ADDR_W-1:0] req_addr;
	} req_t;

	typedef struct packed {
		logic [RES_ADDR_W-1:0]   result_addr;
		logic [1:0]              status;
		logic [FREE_BYTES_W-1:0] free_bytes;
	} res_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_INIT0,
		S_INIT1,
		S_IDLE,
		S_DEC,
		S_A_WALK,
		S_A_UNLINK,
		S_A_SPLIT,
		S_A_MARK,
		S_F_CHK,
		S_I_START,
		S_I_WALK,
		S_I_MERGE,
		S_I_NEXT,
		S_I_SUCC,
		S_I_WB,
		S_I_LINK,
		S_FIN
	} state_t;

endpackage

>>> hw/rtl/ffha_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ffha_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg and ffha_ram (header store).
//
//  channel  | valid     | stall     | payload
//  ---------+-----------+-----------+---------------------------
//  request  | in_valid  | in_stall  | in_data  (ffha_pkg::req_t)
//  result   | out_valid | out_stall | out_data (ffha_pkg::res_t)
//  config   | cfg_we    | -         | cfg_wdata (heap_size)
//
// One request is worked on at a time. A transaction does one header-store read per free-list
// node visited, walking the list for the fit search and again for the reinsertion, so its
// duration grows with fragmentation.
// After reset, and after every heap_size write, a clearing pass zeroes the header store,
// one entry a cycle; no request is taken meanwhile.
// A finished result waits in the output register while out_stall is high.
module first_fit_heap_allocator #(
	parameter int unsigned HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
	parameter int unsigned ALIGN_BYTES  = ffha_pkg::ALIGN_BYTES_DEF,
	parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ffha_pkg::req_t                      in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ffha_pkg::res_t                      out_data,
	input  logic                                cfg_we,
	input  logic [ffha_pkg::HEAP_SIZE_W-1:0]    cfg_wdata
);
	import ffha_pkg::*;

	localparam int unsigned UNITS = HEAP_BYTES / ALIGN_BYTES;
	localparam int unsigned AW    = $clog2(UNITS);
	localparam int unsigned LW    = AW + 1;
	localparam int unsigned SW    = $clog2(HEAP_BYTES) + 1;
	localparam int unsigned RW    = (SW > 17 ? SW : 17) + 1;
	localparam int unsigned ASH   = $clog2(ALIGN_BYTES);
	localparam int unsigned EW    = 1 + SW + LW;
	localparam int unsigned RST_HEAP_I = ((65536 > HEAP_BYTES) ? HEAP_BYTES : 65536)
		/ ALIGN_BYTES * ALIGN_BYTES;
	localparam int unsigned RST_SPAN_I = RST_HEAP_I - HEADER_BYTES;
	localparam logic [LW-1:0] NO_LINK  = {LW{1'b1}};
	localparam logic [RW-1:0] HDR_R    = RW'(HEADER_BYTES);
	localparam logic [RW-1:0] HEAP_R   = RW'(HEAP_BYTES);
	localparam logic [RW-1:0] MINH_R   = RW'(4 * HEADER_BYTES);
	localparam logic [RW-1:0] SPLIT_R  = RW'(2 * HEADER_BYTES);
	localparam logic [RW-1:0] RND_R    = RW'(HEADER_BYTES + ALIGN_BYTES - 1);

	function automatic logic [EW-1:0] mk(logic a, logic [SW-1:0] s, logic [LW-1:0] n);
		return {a, s, n};
	endfunction

	function automatic logic [RW-1:0] ubytes(logic [AW-1:0] u);
		return RW'(u) << ASH;
	endfunction

	state_t st_q, st_d;

	// header store port
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic          rd_alloc;
	logic [SW-1:0] rd_size;
	logic [LW-1:0] rd_next;

	assign rd_alloc = rdata[EW-1];
	assign rd_size  = rdata[LW +: SW];
	assign rd_next  = rdata[LW-1:0];

	logic [AW-1:0] clr_q, lh_q, end_q, blk_q, prev_q, b_q, it_q;
	logic [SW-1:0] free_q, bsz_q, blksz_q, prevsz_q, itsz_q;
	logic [LW-1:0] blknext_q, n_q, bnext_q;
	logic          prev_sent_q, it_sent_q, previa_q, itia_q, op_q;
	logic [RW-1:0] reqb_q;
	logic [REQ_SIZE_W-1:0] size_q;
	logic [REQ_ADDR_W-1:0] addr_q;
	logic [RES_ADDR_W-1:0] res_addr_q;
	logic [1:0]            res_st_q;
	logic                  out_valid_q;
	res_t                  out_q;

	// request decode
	logic [RW-1:0] req_bytes, fr_off;
	logic          dec_badfree;
	assign req_bytes = ((RW'(size_q) + RND_R) >> ASH) << ASH;
	assign fr_off    = RW'(addr_q) - HDR_R;
	assign dec_badfree = (RW'(addr_q) < HDR_R) || (fr_off[ASH-1:0] != '0)
		|| ((fr_off >> ASH) >= RW'(end_q));

	// allocation walk and split
	logic          walk_more, walk_fail, do_split;
	logic [RW-1:0] rem;
	assign walk_more = (RW'(rd_size) < reqb_q) && (rd_next != NO_LINK);
	assign walk_fail = (blk_q == end_q) || (RW'(rd_size) < reqb_q);
	assign rem       = RW'(blksz_q) - reqb_q;
	assign do_split  = rem > SPLIT_R;

	// insertion
	logic iw_stop, pred_adj, succ_adj, succ_end;
	assign iw_stop  = (it_q == end_q) || (rd_next == NO_LINK) || (RW'(rd_next) >= RW'(b_q));
	assign pred_adj = !it_sent_q && (ubytes(it_q) + RW'(itsz_q) == ubytes(b_q));
	assign succ_adj = (n_q != NO_LINK) && (ubytes(b_q) + RW'(bsz_q) == (RW'(n_q) << ASH));
	assign succ_end = (n_q == LW'(end_q));

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// configuration clamp
	logic [RW-1:0] cfg_v, cfg_c;
	logic [SW-1:0] cfg_span;
	always_comb begin
		cfg_v = RW'(cfg_wdata);
		if (cfg_v < MINH_R) begin
			cfg_v = MINH_R;
		end else if (cfg_v > HEAP_R) begin
			cfg_v = HEAP_R;
		end
		cfg_c    = (cfg_v >> ASH) << ASH;
		cfg_span = SW'(cfg_c - HDR_R);
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			S_CLR:   if (clr_q == AW'(UNITS - 1)) st_d = S_INIT0;
			S_INIT0: st_d = S_INIT1;
			S_INIT1: st_d = S_IDLE;
			S_IDLE:  if (in_valid) st_d = S_DEC;
			S_DEC: begin
				if (op_q == REQ_ALLOC) begin
					if (size_q == '0 || req_bytes > RW'(free_q)) st_d = S_FIN;
					else st_d = S_A_WALK;
				end else begin
					st_d = dec_badfree ? S_FIN : S_F_CHK;
				end
			end
			S_A_WALK: begin
				if (!walk_more) st_d = walk_fail ? S_FIN : S_A_UNLINK;
			end
			S_A_UNLINK: st_d = do_split ? S_A_SPLIT : S_A_MARK;
			S_A_SPLIT:  st_d = S_I_START;
			S_A_MARK:   st_d = S_FIN;
			S_F_CHK:    st_d = (!rd_alloc || rd_next != NO_LINK) ? S_FIN : S_I_START;
			S_I_START:  st_d = (lh_q >= b_q) ? S_I_MERGE : S_I_WALK;
			S_I_WALK:   if (iw_stop) st_d = S_I_MERGE;
			S_I_MERGE:  st_d = S_I_NEXT;
			S_I_NEXT:   st_d = (succ_adj && !succ_end) ? S_I_SUCC : S_I_WB;
			S_I_SUCC:   st_d = S_I_WB;
			S_I_WB: begin
				if (!it_sent_q && it_q != b_q) st_d = S_I_LINK;
				else st_d = (op_q == REQ_ALLOC) ? S_A_MARK : S_FIN;
			end
			S_I_LINK: st_d = (op_q == REQ_ALLOC) ? S_A_MARK : S_FIN;
			S_FIN:    if (out_free) st_d = S_IDLE;
			default:  st_d = S_IDLE;
		endcase
		if (cfg_we) st_d = S_CLR;
	end

	// memory port and handshake outputs
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		case (st_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			S_INIT0: begin
				we    = 1'b1;
				wdata = mk(1'b0, free_q, LW'(end_q));
			end
			S_INIT1: begin
				we    = 1'b1;
				waddr = end_q;
				wdata = mk(1'b0, '0, NO_LINK);
			end
			S_DEC: raddr = (op_q == REQ_ALLOC) ? lh_q : AW'(fr_off >> ASH);
			S_A_WALK: raddr = rd_next[AW-1:0];
			S_A_UNLINK: begin
				we    = !prev_sent_q;
				waddr = prev_q;
				wdata = mk(previa_q, prevsz_q, blknext_q);
			end
			S_A_SPLIT: begin
				we    = 1'b1;
				waddr = AW'(RW'(blk_q) + (reqb_q >> ASH));
				wdata = mk(1'b0, SW'(rem), NO_LINK);
			end
			S_A_MARK: begin
				we    = 1'b1;
				waddr = blk_q;
				wdata = mk(1'b1, blksz_q, NO_LINK);
			end
			S_F_CHK: begin
				we    = rd_alloc && rd_next == NO_LINK;
				waddr = b_q;
				wdata = mk(1'b0, rd_size, rd_next);
			end
			S_I_START: raddr = lh_q;
			S_I_WALK:  raddr = rd_next[AW-1:0];
			S_I_NEXT:  raddr = n_q[AW-1:0];
			S_I_WB: begin
				we    = 1'b1;
				waddr = b_q;
				wdata = mk(1'b0, bsz_q, bnext_q);
			end
			S_I_LINK: begin
				we    = 1'b1;
				waddr = it_q;
				wdata = mk(itia_q, itsz_q, LW'(b_q));
			end
			default: ;
		endcase
	end

	assign in_stall  = (st_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	ffha_ram #(
		.WIDTH(EW),
		.DEPTH(UNITS)
	) u_hdr (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			clr_q       <= '0;
			lh_q        <= '0;
			end_q       <= AW'(RST_SPAN_I / ALIGN_BYTES);
			free_q      <= SW'(RST_SPAN_I);
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				clr_q  <= '0;
				lh_q   <= '0;
				end_q  <= AW'(cfg_span >> ASH);
				free_q <= cfg_span;
			end else begin
				if (st_q == S_CLR) clr_q <= clr_q + 1'b1;
				case (st_q)
					S_A_UNLINK: if (prev_sent_q) lh_q <= blknext_q[AW-1:0];
					S_A_MARK:   free_q <= free_q - blksz_q;
					S_F_CHK:    if (rd_alloc && rd_next == NO_LINK) free_q <= free_q + rd_size;
					S_I_WB:     if (it_sent_q) lh_q <= b_q;
					default: ;
				endcase
			end
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				op_q       <= in_data.req_type;
				size_q     <= in_data.req_size;
				addr_q     <= in_data.req_addr;
				res_addr_q <= '0;
				res_st_q   <= ST_OK;
			end
			S_DEC: begin
				reqb_q      <= req_bytes;
				blk_q       <= lh_q;
				prev_sent_q <= 1'b1;
				b_q         <= AW'(fr_off >> ASH);
				if (op_q == REQ_ALLOC) begin
					if (size_q == '0) res_st_q <= ST_ZERO;
					else if (req_bytes > RW'(free_q)) res_st_q <= ST_NOFIT;
				end else if (dec_badfree) begin
					res_st_q <= ST_BADFREE;
				end
			end
			S_A_WALK: begin
				if (walk_more) begin
					prev_q      <= blk_q;
					prev_sent_q <= 1'b0;
					previa_q    <= rd_alloc;
					prevsz_q    <= rd_size;
					blk_q       <= rd_next[AW-1:0];
				end else begin
					blksz_q   <= rd_size;
					blknext_q <= rd_next;
					if (walk_fail) res_st_q <= ST_NOFIT;
				end
			end
			S_A_UNLINK: res_addr_q <= RES_ADDR_W'(ubytes(blk_q) + HDR_R);
			S_A_SPLIT: begin
				b_q     <= AW'(RW'(blk_q) + (reqb_q >> ASH));
				bsz_q   <= SW'(rem);
				blksz_q <= SW'(reqb_q);
			end
			S_F_CHK: begin
				bsz_q <= rd_size;
				if (!rd_alloc || rd_next != NO_LINK) res_st_q <= ST_BADFREE;
			end
			S_I_START: begin
				it_sent_q <= (lh_q >= b_q);
				it_q      <= lh_q;
			end
			S_I_WALK: begin
				itia_q <= rd_alloc;
				itsz_q <= rd_size;
				n_q    <= rd_next;
				if (!iw_stop) it_q <= rd_next[AW-1:0];
			end
			S_I_MERGE: begin
				if (it_sent_q) n_q <= LW'(lh_q);
				if (pred_adj) begin
					bsz_q  <= itsz_q + bsz_q;
					itsz_q <= itsz_q + bsz_q;
					b_q    <= it_q;
				end
			end
			S_I_NEXT: bnext_q <= n_q;
			S_I_SUCC: begin
				bsz_q   <= bsz_q + rd_size;
				bnext_q <= rd_next;
			end
			S_FIN: begin
				if (out_free) begin
					out_q.result_addr <= (res_st_q == ST_OK) ? res_addr_q : '0;
					out_q.status      <= res_st_q;
					out_q.free_bytes  <= FREE_BYTES_W'(free_q);
				end
			end
			default: ;
		endcase
	end

	// The free counter never exceeds the largest possible span.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		RW'(free_q) <= HEAP_R - HDR_R)
		else $error("free byte count above heap span");

	// The list head always names a block at or before the end marker.
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_CLR) |-> (lh_q <= end_q))
		else $error("list head beyond end marker");

	// An accepted transaction is always followed by decode.
	a_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !cfg_we) |=> (st_q == S_DEC))
		else $error("accepted request not decoded");

	// A result is only loaded when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("pending result overwritten");

endmodule

>>> sim/first_fit_heap_allocator_tb.sv
// Self-checking testbench for the first-fit heap allocator with coalescing.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL; the allocator
// behaviour is mirrored by a behavioural heap inside this file.
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	localparam int UNITS     = HEAP_BYTES_DEF / ALIGN_BYTES_DEF;
	localparam int NO_LINK   = -1;
	localparam int HEAD_LINK = -2;
	localparam int IDLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	res_t out_data;
	logic cfg_we = 1'b0;
	logic [HEAP_SIZE_W-1:0] cfg_wdata = '0;

	first_fit_heap_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// Behavioural heap: block sizes in bytes, links as unit indexes.
	int unsigned blk_size [UNITS];
	int          blk_next [UNITS];
	bit          blk_used [UNITS];
	int          free_head;
	int          end_unit;
	int unsigned free_total;
	int unsigned heap_bytes;

	res_t pending_results [$];
	int   live_addrs [$];
	int   errors = 0;
	int   results_seen = 0;
	int   idle_cycles = 0;
	int   n_alloc_ok = 0, n_free_ok = 0, n_rejects = 0;
	bit   calm = 1'b0;

	function automatic int get_link(int u);
		return (u == HEAD_LINK) ? free_head : blk_next[u];
	endfunction

	function automatic void put_link(int u, int v);
		if (u == HEAD_LINK) begin
			free_head = v;
		end else begin
			blk_next[u] = v;
		end
	endfunction

	function automatic void heap_rebuild(int unsigned v);
		int unsigned span;
		if (v < 4 * HEADER_BYTES_DEF) v = 4 * HEADER_BYTES_DEF;
		if (v > HEAP_BYTES_DEF) v = HEAP_BYTES_DEF;
		heap_bytes = (v / ALIGN_BYTES_DEF) * ALIGN_BYTES_DEF;
		span = heap_bytes - HEADER_BYTES_DEF;
		for (int i = 0; i < UNITS; i++) begin
			blk_size[i] = 0;
			blk_next[i] = 0;
			blk_used[i] = 1'b0;
		end
		end_unit = span / ALIGN_BYTES_DEF;
		blk_size[0] = span;
		blk_next[0] = end_unit;
		blk_size[end_unit] = 0;
		blk_next[end_unit] = NO_LINK;
		free_head = 0;
		free_total = span;
		live_addrs.delete();
	endfunction

	function automatic void list_insert(int b);
		int it, n;
		it = HEAD_LINK;
		for (int g = 0; g < UNITS + 2 && it != end_unit; g++) begin
			n = get_link(it);
			if (n == NO_LINK || n >= b) break;
			it = n;
		end
		if (it != HEAD_LINK && it * ALIGN_BYTES_DEF + blk_size[it] == b * ALIGN_BYTES_DEF) begin
			blk_size[it] += blk_size[b];
			b = it;
		end
		n = get_link(it);
		if (n != NO_LINK && b * ALIGN_BYTES_DEF + blk_size[b] == n * ALIGN_BYTES_DEF) begin
			if (n != end_unit) begin
				blk_size[b] += blk_size[n];
				blk_next[b] = blk_next[n];
			end else begin
				blk_next[b] = end_unit;
			end
		end else begin
			blk_next[b] = n;
		end
		if (it != b) put_link(it, b);
	endfunction

	function automatic res_t predict_request(req_t rq);
		res_t r;
		int unsigned need;
		int prev, blk, nb, u, off;
		r = '0;
		if (rq.req_type == REQ_ALLOC) begin
			if (rq.req_size == 0) begin
				r.status = ST_ZERO;
			end else begin
				need = ((rq.req_size + HEADER_BYTES_DEF + ALIGN_BYTES_DEF - 1)
					/ ALIGN_BYTES_DEF) * ALIGN_BYTES_DEF;
				r.status = ST_NOFIT;
				if (need <= free_total) begin
					prev = HEAD_LINK;
					blk = free_head;
					for (int g = 0; g < UNITS + 2 && blk_size[blk] < need
							&& blk_next[blk] != NO_LINK; g++) begin
						prev = blk;
						blk = blk_next[blk];
					end
					if (blk != end_unit && blk_size[blk] >= need) begin
						put_link(prev, blk_next[blk]);
						r.result_addr = RES_ADDR_W'(blk * ALIGN_BYTES_DEF + HEADER_BYTES_DEF);
						if (blk_size[blk] - need > 2 * HEADER_BYTES_DEF) begin
							nb = blk + need / ALIGN_BYTES_DEF;
							blk_size[nb] = blk_size[blk] - need;
							blk_used[nb] = 1'b0;
							blk_size[blk] = need;
							list_insert(nb);
						end
						free_total -= blk_size[blk];
						blk_used[blk] = 1'b1;
						blk_next[blk] = NO_LINK;
						r.status = ST_OK;
						live_addrs.push_back(r.result_addr);
					end
				end
			end
		end else begin
			r.status = ST_BADFREE;
			if (rq.req_addr >= HEADER_BYTES_DEF) begin
				off = rq.req_addr - HEADER_BYTES_DEF;
				u = off / ALIGN_BYTES_DEF;
				if (off % ALIGN_BYTES_DEF == 0 && u < end_unit && blk_used[u]
						&& blk_next[u] == NO_LINK) begin
					blk_used[u] = 1'b0;
					free_total += blk_size[u];
					list_insert(u);
					r.status = ST_OK;
					foreach (live_addrs[i]) begin
						if (live_addrs[i] == rq.req_addr) begin
							live_addrs.delete(i);
							break;
						end
					end
				end
			end
		end
		r.free_bytes = FREE_BYTES_W'(free_total);
		if (r.status == ST_OK) begin
			if (rq.req_type == REQ_ALLOC) n_alloc_ok++; else n_free_ok++;
		end else begin
			n_rejects++;
		end
		return r;
	endfunction

	// Sends one request; the prediction is made when the transaction is accepted.
	task automatic send_request(bit kind, int unsigned size, int unsigned addr);
		req_t rq;
		while (!calm && $urandom_range(99) < 38) @(posedge clk);
		rq.req_type = kind;
		rq.req_size = REQ_SIZE_W'(size);
		rq.req_addr = REQ_ADDR_W'(addr);
		in_valid <= 1'b1;
		in_data <= rq;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_request(rq));
		in_valid <= 1'b0;
		// The block stays busy past acceptance anyway, decoding the request.
		@(posedge clk);
	endtask

	task automatic send_alloc(int unsigned size);
		send_request(REQ_ALLOC, size, $urandom_range(65535));
	endtask

	task automatic send_free(int unsigned addr);
		send_request(REQ_FREE, $urandom_range(65535), addr);
	endtask

	task automatic drain;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (UNITS + 40) @(posedge clk);
	endtask

	task automatic write_heap_size(int unsigned v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= HEAP_SIZE_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		heap_rebuild(v & 17'h1FFFF);
	endtask

	task automatic test_directed_defaults;
		send_alloc(0);
		send_alloc(16'hFFFF);
		send_alloc(1);
		send_alloc(24);
		send_alloc(25);
		send_free(0);
		send_free(8);
		send_free(21);
		send_free(16'hFFF8);
		send_free(16);
		send_free(16);
		send_free(40);
		send_free(32);
		send_alloc(65000);
		send_alloc(65535 - 32);
		send_alloc(100);
	endtask

	task automatic test_small_heap;
		write_heap_size(0);
		send_alloc(8);
		send_alloc(8);
		send_alloc(8);
		send_free(16);
		send_free(16 + 24);
		write_heap_size(17'h1FFFF);
		send_alloc(65000);
		write_heap_size(1003);
		send_alloc(300);
		send_alloc(300);
		send_alloc(400);
	endtask

	task automatic random_phase(int count, int max_size);
		int k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(99);
			calm = (i >= count / 3 && i < count / 3 + 80);
			if (k < 48) begin
				send_alloc($urandom_range(max_size));
			end else if (k < 88 && live_addrs.size() != 0) begin
				send_free(live_addrs[$urandom_range(live_addrs.size() - 1)]);
			end else if (k < 94) begin
				send_free($urandom_range(65535));
			end else begin
				send_alloc($urandom_range(65535));
			end
		end
		calm = 1'b0;
	endtask

	task automatic test_random;
		write_heap_size(4096);
		random_phase(350, 300);
		write_heap_size(65536);
		random_phase(450, 2000);
		write_heap_size(512);
		random_phase(350, 120);
	endtask

	always @(posedge clk) begin
		if (calm || $urandom_range(99) >= 38) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b1;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: %p", $time, out_data);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.result_addr !== want.result_addr) begin
					$display("%0t: result_addr expected %0d actual %0d", $time,
						want.result_addr, out_data.result_addr);
					errors++;
				end
				if (out_data.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, out_data.status);
					errors++;
				end
				if (out_data.free_bytes !== want.free_bytes) begin
					$display("%0t: free_bytes expected %0d actual %0d", $time,
						want.free_bytes, out_data.free_bytes);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which no transaction moves on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("first_fit_heap_allocator_tb NOT OK");
			$finish;
		end
	end

	initial begin
		heap_rebuild(65536);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_defaults();
		test_small_heap();
		test_random();
		drain();
		if (pending_results.size() != 0) errors++;
		$display("Checked %0d results: %0d allocations, %0d frees, %0d rejected requests,",
			results_seen, n_alloc_ok, n_free_ok, n_rejects);
		$display("over heap sizes from the minimum to the full 64 KiB.");
		if (errors == 0) begin
			$display("first_fit_heap_allocator_tb OK");
		end else begin
			$display("first_fit_heap_allocator_tb NOT OK");
		end
		$finish;
	end

endmodule
